// ===== sv/lrut_pkg.sv =====
//------------------------------------------------------------------------------
// lrut_pkg
// shared types and constants for the lazy range update / query tree
//------------------------------------------------------------------------------
package lrut_pkg;

	localparam int unsigned LEAVES = 1024;
	localparam int unsigned LVL_W = $clog2(LEAVES);
	localparam int unsigned SPAN = 1 << LVL_W;
	localparam int unsigned NODES = 2 * SPAN - 1;
	localparam int unsigned NODE_W = $clog2(NODES);
	localparam int unsigned IDX_W = 11;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned DEPTH_W = $clog2(LVL_W + 2);

	localparam logic [DATA_W-1:0] MIN_NEUTRAL = {1'b0, {(DATA_W - 1){1'b1}}};

	typedef enum logic [0:0] {
		REG_MODE = 1'b0,
		REG_INIT = 1'b1
	} reg_idx_t;

	// bit 0 picks sum over min, bit 1 picks add over assign
	typedef enum logic [1:0] {
		MODE_ASSIGN_MIN = 2'd0,
		MODE_ASSIGN_SUM = 2'd1,
		MODE_ADD_MIN    = 2'd2,
		MODE_ADD_SUM    = 2'd3
	} mode_t;

	typedef enum logic [0:0] {
		ACT_UPDATE = 1'b0,
		ACT_QUERY  = 1'b1
	} action_t;

	// datapath commands from the sequencer
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLR,
		DP_RD_NODE,
		DP_RD_KIDS,
		DP_PUSH,
		DP_APPLY,
		DP_MERGE,
		DP_ACC,
		DP_PUSH_FRAME,
		DP_POP_FRAME,
		DP_START
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [NODE_W-1:0] clr_addr;
	} dp_cmd_t;

	typedef struct packed {
		logic disjoint;
		logic covered;
		logic leaf;
		logic pending;
		logic stack_empty;
		logic right_side;
	} dp_stat_t;

	function automatic logic [DATA_W-1:0] scale(input logic [DATA_W-1:0] x,
			input logic [DEPTH_W-1:0] lvl);
		// span of a node at depth lvl is a power of two: multiply is a shift
		scale = x << (LVL_W - lvl);
	endfunction

endpackage

// ===== sv/lrut_dp.sv =====
//------------------------------------------------------------------------------
// lrut_dp
// node store, walk stack and arithmetic for the tree walk
//------------------------------------------------------------------------------
module lrut_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrut_pkg::dp_cmd_t           cmd,
	output lrut_pkg::dp_stat_t          stat,
	input  logic [1:0]                  mode,
	input  logic [lrut_pkg::DATA_W-1:0] init_value,
	input  logic                        action,
	input  logic [lrut_pkg::IDX_W-1:0]  range_lo,
	input  logic [lrut_pkg::IDX_W-1:0]  range_hi,
	input  logic [lrut_pkg::DATA_W-1:0] operand,
	output logic [lrut_pkg::DATA_W-1:0] result
);
	localparam int unsigned NW = lrut_pkg::NODE_W;
	localparam int unsigned DW = lrut_pkg::DATA_W;
	localparam int unsigned LW = lrut_pkg::LVL_W;
	localparam int unsigned PW = lrut_pkg::DEPTH_W;
	localparam int unsigned EW = LW + 1;
	localparam logic [lrut_pkg::IDX_W-1:0] LEAVES_C = lrut_pkg::IDX_W'(lrut_pkg::LEAVES);

	// node record: aggregate, tag, pending
	logic [DW-1:0] agg_mem [lrut_pkg::NODES];
	logic [DW-1:0] tag_mem [lrut_pkg::NODES];
	logic          pnd_mem [lrut_pkg::NODES];

	// walk frames, one per depth
	logic [NW-1:0] stk_node [LW + 1];
	logic [EW-1:0] stk_l    [LW + 1];
	logic          stk_side [LW + 1];

	logic [PW-1:0] sp_q;
	logic [NW-1:0] k_q;
	logic [EW-1:0] l_q;
	logic          side_q;
	logic [EW-1:0] a_q, b_q;
	logic [DW-1:0] x_q, acc_q;
	logic          query_q;
	logic [DW-1:0] agg_rd_q, tag_rd_q, lagg_q, ragg_q, ltag_q, rtag_q;
	logic          pnd_rd_q, lpnd_q, rpnd_q;

	logic is_sum, is_add;
	assign is_sum = mode[0];
	assign is_add = mode[1];

	logic [EW-1:0] r_w, lo_c, hi_c;
	logic [NW-1:0] lk_w, rk_w;
	logic [DW-1:0] neutral_w, merge_w, init_w;
	assign r_w = l_q + (EW'(lrut_pkg::SPAN) >> sp_q);
	assign lk_w = {k_q[NW-2:0], 1'b1};
	assign rk_w = NW'({k_q[NW-2:0], 1'b0} + NW'(2));
	assign lo_c = (range_lo > LEAVES_C) ? EW'(lrut_pkg::LEAVES) : EW'(range_lo);
	assign hi_c = (range_hi > LEAVES_C) ? EW'(lrut_pkg::LEAVES) : EW'(range_hi);
	assign neutral_w = is_sum ? '0 : lrut_pkg::MIN_NEUTRAL;
	assign merge_w = is_sum ? lagg_q + ragg_q :
		(($signed(lagg_q) <= $signed(ragg_q)) ? lagg_q : ragg_q);

	// depth of the node being cleared, from its index
	logic [PW-1:0] clr_lvl;
	always_comb begin
		clr_lvl = '0;
		for (int i = 1; i <= LW; i++) begin
			if ({1'b0, cmd.clr_addr} + (NW + 1)'(1) >= (NW + 1)'(1 << i)) clr_lvl = PW'(i);
		end
	end
	assign init_w = is_sum ? lrut_pkg::scale(init_value, clr_lvl) : init_value;

	// tag applied to a node at depth lvl with value v on top of an old record
	function automatic logic [DW-1:0] new_agg(input logic [DW-1:0] old,
			input logic [DW-1:0] v, input logic [PW-1:0] lvl, input logic sm,
			input logic ad);
		logic [DW-1:0] sv;
		sv = sm ? lrut_pkg::scale(v, lvl) : v;
		new_agg = ad ? old + sv : sv;
	endfunction

	function automatic logic [DW-1:0] new_tag(input logic [DW-1:0] old,
			input logic op, input logic [DW-1:0] v, input logic ad);
		new_tag = (ad && op) ? old + v : v;
	endfunction

	logic [PW-1:0] kid_lvl;
	assign kid_lvl = sp_q + PW'(1);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lrut_pkg::DP_CLR: begin
				agg_mem[cmd.clr_addr] <= init_w;
				tag_mem[cmd.clr_addr] <= '0;
				pnd_mem[cmd.clr_addr] <= 1'b0;
			end
			lrut_pkg::DP_RD_NODE: begin
				agg_rd_q <= agg_mem[k_q];
				tag_rd_q <= tag_mem[k_q];
				pnd_rd_q <= pnd_mem[k_q];
			end
			lrut_pkg::DP_RD_KIDS: begin
				lagg_q <= agg_mem[lk_w];
				ragg_q <= agg_mem[rk_w];
				ltag_q <= tag_mem[lk_w];
				rtag_q <= tag_mem[rk_w];
				lpnd_q <= pnd_mem[lk_w];
				rpnd_q <= pnd_mem[rk_w];
			end
			lrut_pkg::DP_PUSH: begin
				agg_mem[lk_w] <= new_agg(lagg_q, tag_rd_q, kid_lvl, is_sum, is_add);
				tag_mem[lk_w] <= new_tag(ltag_q, lpnd_q, tag_rd_q, is_add);
				pnd_mem[lk_w] <= (kid_lvl != PW'(LW));
				agg_mem[rk_w] <= new_agg(ragg_q, tag_rd_q, kid_lvl, is_sum, is_add);
				tag_mem[rk_w] <= new_tag(rtag_q, rpnd_q, tag_rd_q, is_add);
				pnd_mem[rk_w] <= (kid_lvl != PW'(LW));
			end
			// a split node holds no tag once the walk goes below it
			lrut_pkg::DP_PUSH_FRAME: begin
				tag_mem[k_q] <= '0;
				pnd_mem[k_q] <= 1'b0;
			end
			lrut_pkg::DP_APPLY: begin
				agg_mem[k_q] <= new_agg(agg_rd_q, x_q, sp_q, is_sum, is_add);
				tag_mem[k_q] <= new_tag(tag_rd_q, pnd_rd_q, x_q, is_add);
				pnd_mem[k_q] <= (sp_q != PW'(LW));
			end
			lrut_pkg::DP_MERGE: agg_mem[k_q] <= merge_w;
			default: ;
		endcase
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			unique case (cmd.op)
				lrut_pkg::DP_START: begin
					sp_q    <= '0;
					k_q     <= '0;
					l_q     <= '0;
					side_q  <= 1'b0;
					a_q     <= lo_c;
					b_q     <= hi_c;
					x_q     <= operand;
					query_q <= action;
					acc_q   <= neutral_w;
				end
				lrut_pkg::DP_ACC: begin
					// fold a covered node into the running result
					if (query_q && stat.covered && !stat.disjoint) begin
						acc_q <= is_sum ? acc_q + agg_rd_q :
							(($signed(acc_q) <= $signed(agg_rd_q)) ? acc_q : agg_rd_q);
					end
				end
				lrut_pkg::DP_PUSH_FRAME: begin
					stk_node[sp_q] <= k_q;
					stk_l[sp_q]    <= l_q;
					stk_side[sp_q] <= side_q;
					sp_q   <= sp_q + PW'(1);
					k_q    <= lk_w;
					side_q <= 1'b0;
				end
				lrut_pkg::DP_POP_FRAME: begin
					if (!side_q) begin
						// left child done, move to right sibling
						k_q    <= NW'(k_q + NW'(1));
						l_q    <= l_q + (EW'(lrut_pkg::SPAN) >> sp_q);
						side_q <= 1'b1;
					end else begin
						sp_q   <= sp_q - PW'(1);
						k_q    <= stk_node[sp_q - PW'(1)];
						l_q    <= stk_l[sp_q - PW'(1)];
						side_q <= stk_side[sp_q - PW'(1)];
					end
				end
				default: ;
			endcase
		end
	end

	// an empty range counts as disjoint everywhere, so the walk ends at the root
	assign stat.disjoint    = (r_w <= a_q) || (b_q <= l_q) || (b_q <= a_q);
	assign stat.covered     = (a_q <= l_q) && (r_w <= b_q);
	assign stat.leaf        = (sp_q == PW'(LW));
	assign stat.pending     = pnd_rd_q;
	assign stat.stack_empty = (sp_q == '0);
	assign stat.right_side  = side_q;
	assign result = acc_q;

	property p_sp_bound;
		@(posedge clk) disable iff (!arst_n) sp_q <= PW'(LW);
	endproperty
	a_sp_bound: assert property (p_sp_bound) else $error("walk depth overflow");

	property p_push_descends;
		@(posedge clk) disable iff (!arst_n)
			cmd.op == lrut_pkg::DP_PUSH_FRAME |=> sp_q == $past(sp_q) + PW'(1);
	endproperty
	a_push_descends: assert property (p_push_descends) else $error("push lost depth");

	property p_no_push_leaf;
		@(posedge clk) disable iff (!arst_n)
			cmd.op == lrut_pkg::DP_PUSH_FRAME |-> !stat.leaf;
	endproperty
	a_no_push_leaf: assert property (p_no_push_leaf) else $error("descend below leaf");

endmodule

// ===== sv/lrut_ctrl.sv =====
//------------------------------------------------------------------------------
// lrut_ctrl
// sequencer for store reload and the depth-first tree walk
//------------------------------------------------------------------------------
module lrut_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               reload,
	input  logic               in_take,
	input  logic               action,
	input  logic               out_busy,
	input  lrut_pkg::dp_stat_t stat,
	output lrut_pkg::dp_cmd_t  cmd,
	output logic               idle,
	output logic               res_load
);
	localparam int unsigned NW = lrut_pkg::NODE_W;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_VISIT,
		S_CHECK,
		S_PULL,
		S_PUSH,
		S_DESCEND,
		S_RET,
		S_KIDS,
		S_MERGE,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [NW-1:0] clr_q;
	logic          query_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			query_q <= 1'b0;
		end else if (reload) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= NW'(clr_q + NW'(1));
					if (clr_q == NW'(lrut_pkg::NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_take) begin
						query_q <= action;
						state_q <= S_VISIT;
					end
				end
				S_VISIT: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.disjoint || stat.covered) state_q <= S_RET;
					else if (stat.pending) state_q <= S_PULL;
					else state_q <= S_DESCEND;
				end
				S_PULL: state_q <= S_PUSH;
				S_PUSH: state_q <= S_DESCEND;
				S_DESCEND: state_q <= S_VISIT;
				S_RET: begin
					if (stat.stack_empty) state_q <= S_DONE;
					else if (!stat.right_side) state_q <= S_VISIT;
					else if (!query_q) state_q <= S_KIDS;
					else state_q <= S_RET;
				end
				S_KIDS: state_q <= S_MERGE;
				S_MERGE: state_q <= stat.stack_empty ? S_DONE : S_RET;
				S_DONE: if (!(query_q && out_busy)) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode; RET pops a frame, after update we merge the parent
	always_comb begin
		cmd.op = lrut_pkg::DP_NOP;
		cmd.clr_addr = clr_q;
		unique case (state_q)
			S_CLEAR:   cmd.op = lrut_pkg::DP_CLR;
			S_IDLE:    cmd.op = in_take ? lrut_pkg::DP_START : lrut_pkg::DP_NOP;
			S_VISIT:   cmd.op = lrut_pkg::DP_RD_NODE;
			S_CHECK:   cmd.op = (!query_q && stat.covered && !stat.disjoint) ?
				lrut_pkg::DP_APPLY : lrut_pkg::DP_ACC;
			S_PULL:    cmd.op = lrut_pkg::DP_RD_KIDS;
			S_PUSH:    cmd.op = lrut_pkg::DP_PUSH;
			S_DESCEND: cmd.op = lrut_pkg::DP_PUSH_FRAME;
			S_RET:     cmd.op = stat.stack_empty ? lrut_pkg::DP_NOP :
				lrut_pkg::DP_POP_FRAME;
			S_KIDS:    cmd.op = lrut_pkg::DP_RD_KIDS;
			S_MERGE:   cmd.op = lrut_pkg::DP_MERGE;
			default:   cmd.op = lrut_pkg::DP_NOP;
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && query_q && !out_busy;

	property p_clear_blocks;
		@(posedge clk) disable iff (!arst_n) state_q == S_CLEAR |-> !res_load;
	endproperty
	a_clear_blocks: assert property (p_clear_blocks) else $error("result during clear");

	property p_start_idle;
		@(posedge clk) disable iff (!arst_n)
			cmd.op == lrut_pkg::DP_START |-> state_q == S_IDLE;
	endproperty
	a_start_idle: assert property (p_start_idle) else $error("start while busy");

	property p_apply_update;
		@(posedge clk) disable iff (!arst_n)
			cmd.op == lrut_pkg::DP_APPLY |-> !query_q;
	endproperty
	a_apply_update: assert property (p_apply_update) else $error("query wrote store");

endmodule

// ===== sv/lazy_range_update_query_tree.sv =====
//------------------------------------------------------------------------------
// lazy_range_update_query_tree
// lazy segment tree with range assign/add and range min/sum
//------------------------------------------------------------------------------
// usage:
//   in channel: in_valid/in_stall with action, range_lo, range_hi, operand.
//   an update returns nothing, a query returns one aggregate on the out
//   channel (out_valid/out_stall). one item is worked at a time.
//   the walk is depth-first through one node store: a node outside or inside
//   the range passes VISIT, CHECK and RET, a split node VISIT, CHECK, DESCEND
//   and RET, on an update also KIDS and MERGE, and PULL and PUSH when its
//   pending tag is pushed down to the children. a walk visits at most 39
//   nodes, and the next item is accepted only once the walk is done.
//   the result sits in an output register; the next item is accepted while
//   it waits, but a second query holds in its last step until it is taken.
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; in_stall
//   is also high while cfg_valid is.
//   reset and every configuration write start a clearing pass over all
//   2047 nodes, one per cycle; no item is accepted meanwhile.
//------------------------------------------------------------------------------
module lazy_range_update_query_tree (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [lrut_pkg::IDX_W-1:0]  range_lo,
	input  logic [lrut_pkg::IDX_W-1:0]  range_hi,
	input  logic signed [lrut_pkg::DATA_W-1:0] operand,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [lrut_pkg::DATA_W-1:0] aggregate,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [lrut_pkg::DATA_W-1:0] cfg_data
);
	logic [1:0]                  mode_q;
	logic [lrut_pkg::DATA_W-1:0] init_q;
	logic                        cfg_xfer, in_take, idle, res_load;
	lrut_pkg::dp_cmd_t           cmd;
	lrut_pkg::dp_stat_t          stat;
	logic [lrut_pkg::DATA_W-1:0] result;

	assign cfg_ready = 1'b1;
	assign cfg_xfer = cfg_valid && cfg_ready;
	// a configuration write wins over an input transfer in the same cycle
	assign in_stall = !idle || cfg_valid;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= lrut_pkg::MODE_ADD_SUM;
			init_q <= '0;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				lrut_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				lrut_pkg::REG_INIT: init_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) aggregate <= result;
	end

	lrut_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.reload   (cfg_xfer),
		.in_take  (in_take),
		.action   (action),
		.out_busy (out_valid && out_stall),
		.stat     (stat),
		.cmd      (cmd),
		.idle     (idle),
		.res_load (res_load)
	);

	lrut_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode_q),
		.init_value (init_q),
		.action     (action),
		.range_lo   (range_lo),
		.range_hi   (range_hi),
		.operand    (operand),
		.result     (result)
	);

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
			out_valid && out_stall |=> out_valid && $stable(aggregate);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result dropped");

	property p_no_take_busy;
		@(posedge clk) disable iff (!arst_n) in_take |-> idle;
	endproperty
	a_no_take_busy: assert property (p_no_take_busy) else $error("take while busy");

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n) res_load |-> !(out_valid && out_stall);
	endproperty
	a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

endmodule

// ===== test/lazy_range_update_query_tree_tb.sv =====
//------------------------------------------------------------------------------
// lazy_range_update_query_tree_tb
// self-checking bench for the lazy range update / query tree: range updates
// and queries are driven in all four modes under several initial values, and
// every returned aggregate is checked against an in-bench copy of the tree
//------------------------------------------------------------------------------
module lazy_range_update_query_tree_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TREE_NODES = 2 * 1024 - 1;
	localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [lrut_pkg::IDX_W-1:0] range_lo = '0;
	logic [lrut_pkg::IDX_W-1:0] range_hi = '0;
	logic signed [lrut_pkg::DATA_W-1:0] operand = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [lrut_pkg::DATA_W-1:0] aggregate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [lrut_pkg::DATA_W-1:0] cfg_data = '0;

	lazy_range_update_query_tree dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow tree
	logic [63:0] node_sum[TREE_NODES];
	logic [63:0] node_tag[TREE_NODES];
	bit node_pend[TREE_NODES];
	logic [1:0] cur_mode;
	logic [63:0] cur_init;

	logic [63:0] expected_aggs[$];
	int unsigned aggs_due = 0;
	int unsigned fail_count = 0;
	bit no_idle = 1'b0;

	function automatic logic [63:0] combine(logic [63:0] a, logic [63:0] b);
		if (cur_mode[0])
			return a + b;
		return ($signed(a) <= $signed(b)) ? a : b;
	endfunction

	function automatic logic [63:0] neutral_val();
		return cur_mode[0] ? 64'd0 : lrut_pkg::MIN_NEUTRAL;
	endfunction

	function automatic void tag_node(int k, int span, logic [63:0] x);
		if (cur_mode[1]) begin
			node_sum[k] = node_sum[k] + (cur_mode[0] ? x * span : x);
			node_tag[k] = node_pend[k] ? node_tag[k] + x : x;
		end else begin
			node_sum[k] = cur_mode[0] ? x * span : x;
			node_tag[k] = x;
		end
		node_pend[k] = (span > 1);
	endfunction

	function automatic void push_tag(int k, int span);
		if (!node_pend[k])
			return;
		if (span > 1) begin
			tag_node(2 * k + 1, span / 2, node_tag[k]);
			tag_node(2 * k + 2, span / 2, node_tag[k]);
		end
		node_pend[k] = 1'b0;
		node_tag[k] = '0;
	endfunction

	function automatic void reload_tree();
		int span;
		for (int d = 0; d <= 10; d++) begin
			span = 1024 >> d;
			for (int k = (1 << d) - 1; k <= (2 << d) - 2; k++) begin
				node_sum[k] = cur_mode[0] ? cur_init * span : cur_init;
				node_tag[k] = '0;
				node_pend[k] = 1'b0;
			end
		end
	endfunction

	function automatic void range_update(int a, int b, logic [63:0] x, int k, int l, int r);
		int m;
		if (r <= a || b <= l)
			return;
		if (a <= l && r <= b) begin
			tag_node(k, r - l, x);
			return;
		end
		push_tag(k, r - l);
		m = l + (r - l) / 2;
		range_update(a, b, x, 2 * k + 1, l, m);
		range_update(a, b, x, 2 * k + 2, m, r);
		node_sum[k] = combine(node_sum[2 * k + 1], node_sum[2 * k + 2]);
	endfunction

	function automatic logic [63:0] range_query(int a, int b, int k, int l, int r);
		int m;
		if (r <= a || b <= l)
			return neutral_val();
		if (a <= l && r <= b)
			return node_sum[k];
		push_tag(k, r - l);
		m = l + (r - l) / 2;
		return combine(range_query(a, b, 2 * k + 1, l, m),
			range_query(a, b, 2 * k + 2, m, r));
	endfunction

	function automatic void predict_item(logic act, int lo, int hi, logic [63:0] x);
		if (lo > 1024) lo = 1024;
		if (hi > 1024) hi = 1024;
		if (act == lrut_pkg::ACT_UPDATE) begin
			if (lo < hi)
				range_update(lo, hi, x, 0, 0, 1024);
		end else begin
			expected_aggs.push_back(lo < hi ? range_query(lo, hi, 0, 0, 1024) : neutral_val());
			aggs_due++;
		end
	endfunction

	// one input transfer; valid stays high when no gap is drawn
	task automatic send_item(logic act, int lo, int hi, logic [63:0] x);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		range_lo <= lo[lrut_pkg::IDX_W-1:0];
		range_hi <= hi[lrut_pkg::IDX_W-1:0];
		operand <= x;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(act, lo, hi, x);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (aggs_due == 0);
		// updates give no result, so let any last walk finish
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic configure(logic [1:0] m, logic [63:0] init);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= lrut_pkg::REG_MODE;
		cfg_data <= {62'd0, m};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cur_mode = m;
		reload_tree();
		cfg_index <= lrut_pkg::REG_INIT;
		cfg_data <= init;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_init = init;
		reload_tree();
	endtask

	function automatic logic [63:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return I64_MAX;
			1: return I64_MIN;
			2: return {{56{1'b0}}, 8'($urandom)} - 64'd100;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_directed();
		send_item(lrut_pkg::ACT_QUERY, 0, 1024, 0);
		send_item(lrut_pkg::ACT_QUERY, 0, 1, 0);
		send_item(lrut_pkg::ACT_QUERY, 1023, 1024, 0);
		send_item(lrut_pkg::ACT_UPDATE, 0, 1024, 64'd5);
		send_item(lrut_pkg::ACT_QUERY, 0, 1024, 0);
		send_item(lrut_pkg::ACT_UPDATE, 3, 700, I64_MAX);
		send_item(lrut_pkg::ACT_QUERY, 2, 701, 0);
		send_item(lrut_pkg::ACT_UPDATE, 500, 2047, I64_MIN);
		send_item(lrut_pkg::ACT_QUERY, 0, 2047, 0);
		send_item(lrut_pkg::ACT_UPDATE, 10, 10, 64'd99);
		send_item(lrut_pkg::ACT_UPDATE, 20, 11, 64'd99);
		send_item(lrut_pkg::ACT_QUERY, 10, 10, 0);
		send_item(lrut_pkg::ACT_QUERY, 600, 5, 0);
		send_item(lrut_pkg::ACT_QUERY, 2047, 2047, 0);
		send_item(lrut_pkg::ACT_QUERY, 1024, 2047, 0);
		send_item(lrut_pkg::ACT_UPDATE, 1023, 1024, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(lrut_pkg::ACT_QUERY, 1000, 1024, 0);
		send_item(lrut_pkg::ACT_UPDATE, 1, 1023, I64_MAX);
		send_item(lrut_pkg::ACT_QUERY, 0, 1024, 0);
	endtask

	task automatic test_random(int count);
		int lo, hi, len;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: begin lo = $urandom_range(0, 2047); hi = $urandom_range(0, 2047); end
				1: begin lo = 0; hi = 1024; end
				default: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
						: $urandom_range(1, 40);
					lo = $urandom_range(0, 1024 - len);
					hi = lo + len;
				end
			endcase
			send_item(logic'($urandom_range(0, 1)), lo, hi, rand_operand());
		end
	endtask

	task automatic test_mode(logic [1:0] m, logic [63:0] init, int count);
		configure(m, init);
		test_directed();
		test_random(count);
	endtask

	// result side: stall drawn per transfer, checked in order
	int stall_left = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_aggs.size() == 0) begin
				$display("%t: unexpected aggregate %h", $realtime, aggregate);
				fail_count++;
			end else begin
				if (aggregate !== expected_aggs[0]) begin
					$display("%t: aggregate expected %h actual %h", $realtime,
						expected_aggs[0], aggregate);
					fail_count++;
				end
				void'(expected_aggs.pop_front());
				aggs_due--;
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 7);
			out_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		cur_mode = lrut_pkg::MODE_ADD_SUM;
		cur_init = '0;
		reload_tree();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(60);
		test_mode(lrut_pkg::MODE_ASSIGN_MIN, 64'd0, 150);
		test_mode(lrut_pkg::MODE_ASSIGN_SUM, 64'd7, 150);
		no_idle = 1'b1;
		test_mode(lrut_pkg::MODE_ADD_MIN, I64_MAX, 150);
		no_idle = 1'b0;
		test_mode(lrut_pkg::MODE_ADD_SUM, I64_MIN, 150);
		test_mode(lrut_pkg::MODE_ADD_MIN, I64_MIN, 80);
		test_mode(lrut_pkg::MODE_ASSIGN_MIN, {$urandom, $urandom}, 80);
		test_mode(lrut_pkg::MODE_ASSIGN_SUM, 64'hFFFF_FFFF_FFFF_FFFF, 80);
		test_mode(lrut_pkg::MODE_ADD_SUM, I64_MAX, 80);
		wait_idle();
		if (fail_count == 0 && expected_aggs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/lrut_pkg.sv
sv/lrut_dp.sv
sv/lrut_ctrl.sv
sv/lazy_range_update_query_tree.sv
test/lazy_range_update_query_tree_tb.sv
